// ----- hw/rtl/bpe_pkg.sv -----
package bpe_pkg;

  // Field formats
  localparam int COORD_WIDTH = 16;            // signed Q2.(COORD_WIDTH-2)
  localparam int PARAM_WIDTH = 16;            // unsigned Q0.PARAM_WIDTH
  localparam int WF          = 30;            // fraction bits of the basis weights
  localparam int NUM_PTS     = 4;             // control points, one lane each
  localparam int DEG_W       = 2;

  // Internal widths
  localparam int UW = WF + 1;                 // Q0.WF value up to and including 1.0
  localparam int WW = UW + 1;                 // weight, up to 3 * 1.0
  localparam int PW = WW + 1 + COORD_WIDTH;   // signed weight times coordinate
  localparam int AW = PW + 2;                 // sum of four products plus rounding
  localparam int RW = AW - WF;                // accumulator after the fraction is dropped

  // Pipeline depth: input reg, two multiply stages, weight select, lanes, sum, finish
  localparam int NUM_STAGES = 7;

  // Stream widths, padded to whole bytes
  localparam int IN_RAW_W   = PARAM_WIDTH + 2 * NUM_PTS * COORD_WIDTH;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 * COORD_WIDTH;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [DEG_W-1:0] {
    DEG_CONST  = 2'd0,
    DEG_LINEAR = 2'd1,
    DEG_QUAD   = 2'd2,
    DEG_CUBIC  = 2'd3
  } degree_t;

  typedef logic [UW-1:0]                 frac_t;
  typedef logic [WW-1:0]                 weight_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PW-1:0]          prod_t;
  typedef logic [NUM_STAGES-1:0]         stage_en_t;

  // Rounded fraction product: (a*b + half) >> WF
  function automatic frac_t rmul(frac_t a, frac_t b);
    logic [2*UW-1:0] p;
    p = ({{UW{1'b0}}, a} * {{UW{1'b0}}, b}) + ((2*UW)'(1) << (WF - 1));
    return p[WF +: UW];
  endfunction

endpackage

// ----- hw/rtl/bezier_point_evaluator.sv -----
// Bezier point evaluator, Bernstein form, degree 1 to 3 (0 = constant p0).
// Input stream: one beat per curve sample. in_tuser carries the degree,
// in_tdata carries t (Q0.16) and four control points (Q2.14). Points above
// the selected degree are ignored.
// Output stream: one beat per input beat, in order, holding the point
// (Q2.14, rounded half up, saturated).
// Throughput: one beat per cycle while out_tready is high. The four basis
// weights come from two multiply stages, four lanes form weight times control
// point in parallel, and the merge stages sum the lanes, round and saturate.
// Every stage holds its beat only while the stage after it is full, so a
// stalled receiver fills the bubbles first; in_tready drops only once all
// seven stages are occupied. The output holds steady until taken.
// Reset (rst_n low, synchronous) empties the pipeline; no state is kept
// between beats.
module bezier_point_evaluator import bpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] curve_param, then p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] degree
  input  logic [DEG_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] point_x, [31:16] point_y
  output logic [OUT_DATA_W-1:0] out_tdata
);

  stage_en_t valid_r, valid_nxt, en;

  logic [PARAM_WIDTH-1:0] t0_r;
  degree_t deg0_r;
  coord_t  px_in [NUM_PTS];
  coord_t  py_in [NUM_PTS];
  coord_t  px_r [4][NUM_PTS];
  coord_t  py_r [4][NUM_PTS];
  weight_t w    [NUM_PTS];
  prod_t   prod_x [NUM_PTS];
  prod_t   prod_y [NUM_PTS];
  coord_t  point_x, point_y;

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  always_comb begin
    valid_nxt[0] = en[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = valid_r[NUM_STAGES-1];

  // unpack control points
  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      px_in[i] = in_tdata[PARAM_WIDTH + (2*i)*COORD_WIDTH +: COORD_WIDTH];
      py_in[i] = in_tdata[PARAM_WIDTH + (2*i+1)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_r     <= in_tdata[PARAM_WIDTH-1:0];
      deg0_r   <= degree_t'(in_tuser);
      px_r[0]  <= px_in;
      py_r[0]  <= py_in;
    end
  end

  // control points ride alongside the weight pipeline
  always_ff @(posedge clk) begin
    for (int k = 1; k < 4; k++) begin
      if (en[k]) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
      end
    end
  end

  bpe_weights u_weights (
    .clk   (clk),
    .en    (en),
    .deg_i (deg0_r),
    .t_i   (t0_r),
    .w_o   (w)
  );

  for (genvar i = 0; i < NUM_PTS; i++) begin : g_lane
    bpe_lane u_lane (
      .clk      (clk),
      .en       (en[4]),
      .w_i      (w[i]),
      .px_i     (px_r[3][i]),
      .py_i     (py_r[3][i]),
      .prod_x_o (prod_x[i]),
      .prod_y_o (prod_y[i])
    );
  end

  bpe_merge u_merge (
    .clk       (clk),
    .en        (en),
    .prod_x_i  (prod_x),
    .prod_y_i  (prod_y),
    .point_x_o (point_x),
    .point_y_o (point_y)
  );

  assign out_tdata = OUT_DATA_W'({point_y, point_x});

endmodule

// ----- hw/rtl/bpe_weights.sv -----
module bpe_weights import bpe_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  degree_t   deg_i,
  input  logic [PARAM_WIDTH-1:0] t_i,
  output weight_t   w_o [NUM_PTS]
);

  frac_t   tf, uf;
  degree_t s1_deg_r, s2_deg_r;
  frac_t   s1_uf_r, s1_tf_r, s1_u2_r, s1_t2_r, s1_ut_r;
  frac_t   s2_uf_r, s2_tf_r, s2_u2_r, s2_t2_r, s2_ut_r;
  frac_t   s2_u3_r, s2_u2t_r, s2_ut2_r, s2_t3_r;
  weight_t w_nxt [NUM_PTS];
  weight_t w_r   [NUM_PTS];

  // t and 1-t in Q0.WF
  assign tf = frac_t'(t_i) << (WF - PARAM_WIDTH);
  assign uf = (frac_t'(1) << WF) - tf;

  // First products: squares and the cross term
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_deg_r <= deg_i;
      s1_uf_r  <= uf;
      s1_tf_r  <= tf;
      s1_u2_r  <= rmul(uf, uf);
      s1_t2_r  <= rmul(tf, tf);
      s1_ut_r  <= rmul(uf, tf);
    end
  end

  // Second products: cubic terms
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_deg_r <= s1_deg_r;
      s2_uf_r  <= s1_uf_r;
      s2_tf_r  <= s1_tf_r;
      s2_u2_r  <= s1_u2_r;
      s2_t2_r  <= s1_t2_r;
      s2_ut_r  <= s1_ut_r;
      s2_u3_r  <= rmul(s1_u2_r, s1_uf_r);
      s2_u2t_r <= rmul(s1_u2_r, s1_tf_r);
      s2_ut2_r <= rmul(s1_uf_r, s1_t2_r);
      s2_t3_r  <= rmul(s1_t2_r, s1_tf_r);
    end
  end

  // Bernstein weights for the selected degree, unused points weigh zero
  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      w_nxt[i] = '0;
    end
    case (s2_deg_r)
      DEG_LINEAR: begin
        w_nxt[0] = weight_t'(s2_uf_r);
        w_nxt[1] = weight_t'(s2_tf_r);
      end
      DEG_QUAD: begin
        w_nxt[0] = weight_t'(s2_u2_r);
        w_nxt[1] = weight_t'(s2_ut_r) << 1;
        w_nxt[2] = weight_t'(s2_t2_r);
      end
      DEG_CUBIC: begin
        w_nxt[0] = weight_t'(s2_u3_r);
        w_nxt[1] = (weight_t'(s2_u2t_r) << 1) + weight_t'(s2_u2t_r);
        w_nxt[2] = (weight_t'(s2_ut2_r) << 1) + weight_t'(s2_ut2_r);
        w_nxt[3] = weight_t'(s2_t3_r);
      end
      default: begin
        // constant curve: point 0 at full weight
        w_nxt[0] = weight_t'(1) << WF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      w_r <= w_nxt;
    end
  end

  assign w_o = w_r;

endmodule

// ----- hw/rtl/bpe_lane.sv -----
module bpe_lane import bpe_pkg::*; (
  input  logic    clk,
  input  logic    en,
  input  weight_t w_i,
  input  coord_t  px_i,
  input  coord_t  py_i,
  output prod_t   prod_x_o,
  output prod_t   prod_y_o
);

  logic signed [WW:0] w_s;
  prod_t prod_x_r, prod_y_r;

  // weight is never negative: zero sign bit
  assign w_s = $signed({1'b0, w_i});

  // weighted control point, x and y
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= PW'(w_s * $signed(px_i));
      prod_y_r <= PW'(w_s * $signed(py_i));
    end
  end

  assign prod_x_o = prod_x_r;
  assign prod_y_o = prod_y_r;

endmodule

// ----- hw/rtl/bpe_merge.sv -----
module bpe_merge import bpe_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  prod_t     prod_x_i [NUM_PTS],
  input  prod_t     prod_y_i [NUM_PTS],
  output coord_t    point_x_o,
  output coord_t    point_y_o
);

  logic signed [AW-1:0] acc_x_nxt, acc_y_nxt, acc_x_r, acc_y_r;
  coord_t point_x_r, point_y_r;

  // drop the fraction (floor) and clip to the coordinate range
  function automatic coord_t finish(logic signed [AW-1:0] a);
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    r  = RW'(a >>> WF);
    hi = $signed({{(RW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
    lo = $signed({{(RW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}});
    if (r > hi) begin
      return hi[COORD_WIDTH-1:0];
    end else if (r < lo) begin
      return lo[COORD_WIDTH-1:0];
    end
    return r[COORD_WIDTH-1:0];
  endfunction

  // lane sum plus half an LSB for rounding
  always_comb begin
    acc_x_nxt = AW'(1) << (WF - 1);
    acc_y_nxt = AW'(1) << (WF - 1);
    for (int i = 0; i < NUM_PTS; i++) begin
      acc_x_nxt = acc_x_nxt + AW'(prod_x_i[i]);
      acc_y_nxt = acc_y_nxt + AW'(prod_y_i[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[6]) begin
      point_x_r <= finish(acc_x_r);
      point_y_r <= finish(acc_y_r);
    end
  end

  assign point_x_o = point_x_r;
  assign point_y_o = point_y_r;

endmodule

// ----- hw/rtl/bpe_checker.sv -----
module bpe_checker import bpe_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set right after reset");

  // input backpressure only when the whole pipe is full and the output is stalled
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("in_tready low without an output stall");

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

endmodule

bind bezier_point_evaluator bpe_checker u_bpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/bezier_point_evaluator_test.sv -----
module bezier_point_evaluator_test;
  import bpe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 1700;
  localparam int BURST_ITEMS = 50;          // back-to-back beats during the hold-off
  localparam int HOLD_CYCLES = 100;         // long receiver hold-off
  localparam int STALL_LIMIT = 4000;        // cycles without any accepted beat
  localparam int MAX_REPORTS = 50;

  localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // One curve sample as it goes into the block
  typedef struct {
    degree_t                deg;
    logic [PARAM_WIDTH-1:0] t;
    coord_t                 px [NUM_PTS];
    coord_t                 py [NUM_PTS];
  } sample_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } point_t;

  // Expected curve points, in order, plus the Bernstein predictor
  class point_board;
    point_t pending_points [$];
    int     errors;
    int     checked;
    int     noted;
    int     sat_hits;
    int     deg_seen [4];

    function coord_t clamp_coord(longint v);
      if (v > longint'(C_MAX)) begin
        sat_hits++;
        return C_MAX;
      end
      if (v < longint'(C_MIN)) begin
        sat_hits++;
        return C_MIN;
      end
      return coord_t'(v);
    endfunction

    // (a*b + half) >> WF on Q0.WF fractions
    function longint unsigned frac_mul(longint unsigned a, longint unsigned b);
      return (a * b + (longint'(1) << (WF - 1))) >> WF;
    endfunction

    function point_t bernstein_point(sample_t s);
      longint unsigned tf, uf, u2, t2;
      longint          w [NUM_PTS];
      longint          ax, ay;
      point_t          p;
      tf = longint'(s.t) << (WF - PARAM_WIDTH);
      uf = (longint'(1) << WF) - tf;
      foreach (w[i]) w[i] = 0;
      case (s.deg)
        DEG_CONST: begin
          w[0] = longint'(1) << WF;
        end
        DEG_LINEAR: begin
          w[0] = uf;
          w[1] = tf;
        end
        DEG_QUAD: begin
          w[0] = frac_mul(uf, uf);
          w[1] = 2 * frac_mul(uf, tf);
          w[2] = frac_mul(tf, tf);
        end
        default: begin
          u2   = frac_mul(uf, uf);
          t2   = frac_mul(tf, tf);
          w[0] = frac_mul(u2, uf);
          w[1] = 3 * frac_mul(u2, tf);
          w[2] = 3 * frac_mul(uf, t2);
          w[3] = frac_mul(t2, tf);
        end
      endcase
      ax = 0;
      ay = 0;
      for (int i = 0; i < NUM_PTS; i++) begin
        ax += w[i] * longint'(s.px[i]);
        ay += w[i] * longint'(s.py[i]);
      end
      // round half up, then floor by arithmetic shift
      p.x = clamp_coord((ax + (longint'(1) <<< (WF - 1))) >>> WF);
      p.y = clamp_coord((ay + (longint'(1) <<< (WF - 1))) >>> WF);
      return p;
    endfunction

    function void note_sample(sample_t s);
      pending_points.push_back(bernstein_point(s));
      deg_seen[s.deg]++;
      noted++;
    endfunction

    task report_mismatch(string what, coord_t got, coord_t want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch at result %0d, %s: got %0d, want %0d", checked, what, got, want);
    endtask

    task check_point(coord_t x, coord_t y);
      point_t e;
      if (pending_points.size() == 0) begin
        report_mismatch("beat with no sample pending", x, 0);
        return;
      end
      e = pending_points.pop_front();
      checked++;
      if (x !== e.x) report_mismatch("point_x", x, e.x);
      if (y !== e.y) report_mismatch("point_y", y, e.y);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [DEG_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  point_board board;
  bit         src_gaps;
  bit         sink_stalls;
  int         holds_asked;
  int         holds_served;
  int         n_directed;

  bezier_point_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // t for step k of a 0.01 sampling loop
  function automatic logic [PARAM_WIDTH-1:0] step_param(int k);
    return PARAM_WIDTH'((longint'(k) << PARAM_WIDTH) / 100);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 19))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int      r;
    s.deg = ($urandom_range(0, 19) == 0) ? DEG_CONST : degree_t'($urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < 8)       s.t = '0;
    else if (r < 14) s.t = '1;
    else if (r < 30) s.t = step_param($urandom_range(0, 99));
    else             s.t = PARAM_WIDTH'($urandom);
    for (int i = 0; i < NUM_PTS; i++) begin
      s.px[i] = rand_coord();
      s.py[i] = rand_coord();
    end
    return s;
  endfunction

  // Offer one beat, hold it until taken, then maybe go idle
  task automatic send_sample(input sample_t s);
    logic [IN_DATA_W-1:0] d;
    int                   gap;
    d = '0;
    d[PARAM_WIDTH-1:0] = s.t;
    for (int i = 0; i < NUM_PTS; i++) begin
      d[PARAM_WIDTH + 2*i*COORD_WIDTH     +: COORD_WIDTH] = s.px[i];
      d[PARAM_WIDTH + (2*i+1)*COORD_WIDTH +: COORD_WIDTH] = s.py[i];
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= s.deg;
    do @(posedge clk); while (!in_tready);
    board.note_sample(s);
    gap = src_gaps ? (($urandom_range(0, 99) < 55) ? 0 : idle_len()) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random traffic: sampling-loop sweeps over fixed control points, and loose samples
  task automatic random_items(input int upto);
    sample_t s;
    int      k0;
    int      len;
    while (board.noted < upto) begin
      s = rand_sample();
      if ($urandom_range(0, 2) == 0) begin
        k0  = $urandom_range(0, 99);
        len = $urandom_range(5, 30);
        for (int k = k0; k < 100 && k < k0 + len && board.noted < upto; k++) begin
          s.t = step_param(k);
          send_sample(s);
        end
      end else begin
        send_sample(s);
      end
    end
  endtask

  // Receiver: check taken beats, then decide readiness for the next cycle
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_tvalid && out_tready)
        board.check_point(coord_t'(out_tdata[COORD_WIDTH-1:0]),
                          coord_t'(out_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
      if (stall_left > 0)
        stall_left--;
      else if (holds_served != holds_asked) begin
        holds_served++;
        stall_left = HOLD_CYCLES;
      end else if (sink_stalls && $urandom_range(0, 99) < 25)
        stall_left = idle_len();
      out_tready <= (stall_left == 0);
      @(posedge clk);
    end
  end

  // Watchdog: no beat on either side for too long ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("bezier_point_evaluator_test: errors");
    $finish;
  end

  initial begin
    sample_t s;
    board       = new();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= DEG_CONST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: t at both ends and flat extreme curves for every degree
    for (int d = 0; d < 4; d++) begin
      s     = rand_sample();
      s.deg = degree_t'(d);
      s.t   = '0;
      send_sample(s);
      s.t   = '1;
      send_sample(s);
      for (int i = 0; i < NUM_PTS; i++) begin
        s.px[i] = C_MAX;
        s.py[i] = C_MIN;
      end
      s.t = PARAM_WIDTH'($urandom);
      send_sample(s);
    end
    // opposite extremes, cubic
    for (int i = 0; i < NUM_PTS; i++) begin
      s.px[i] = C_MIN;
      s.py[i] = C_MAX;
    end
    s.t = step_param(50);
    send_sample(s);
    // alternating extremes, cubic midpoint
    for (int i = 0; i < NUM_PTS; i++) begin
      s.px[i] = (i == 0 || i == 3) ? C_MIN : C_MAX;
      s.py[i] = (i == 0 || i == 3) ? C_MAX : C_MIN;
    end
    s.t = {1'b1, {(PARAM_WIDTH-1){1'b0}}};
    send_sample(s);
    // smallest nonzero t, linear
    s     = rand_sample();
    s.deg = DEG_LINEAR;
    s.t   = PARAM_WIDTH'(1);
    send_sample(s);
    // linear with unused points at the extremes
    s.px[2] = C_MAX;
    s.py[2] = C_MIN;
    s.px[3] = C_MIN;
    s.py[3] = C_MAX;
    s.t     = PARAM_WIDTH'($urandom);
    send_sample(s);
    // a few sampling-loop steps, quadratic
    s     = rand_sample();
    s.deg = DEG_QUAD;
    foreach (s.px[i]) s.px[i] = rand_coord();
    s.t = step_param(1);
    send_sample(s);
    s.t = step_param(50);
    send_sample(s);
    s.t = step_param(99);
    send_sample(s);
    n_directed = board.noted;

    // Random with idling on both sides
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    random_items(ITEMS / 2);

    // Receiver holds off while beats keep coming: the pipeline fills and stalls
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    holds_asked++;
    random_items(board.noted + BURST_ITEMS);

    // Full rate both sides
    random_items(board.noted + 200);

    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    random_items(ITEMS);
    in_tvalid <= 1'b0;

    while (board.pending_points.size() != 0) @(posedge clk);
    repeat (2 * NUM_STAGES) @(posedge clk);

    $display("covered %0d curve samples (%0d directed): const %0d, linear %0d, quad %0d, cubic %0d",
             board.noted, n_directed, board.deg_seen[DEG_CONST], board.deg_seen[DEG_LINEAR],
             board.deg_seen[DEG_QUAD], board.deg_seen[DEG_CUBIC]);
    $display("%0d points checked, %0d saturated coordinates, %0d long receiver hold-off(s)",
             board.checked, board.sat_hits, holds_served);
    if (board.errors == 0)
      $display("bezier_point_evaluator_test: clean");
    else
      $display("bezier_point_evaluator_test: errors");
    $finish;
  end

endmodule
